>>> sv/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants for the terminal key decoder with cursor.
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

  localparam int unsigned PosW = 12;

  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_QUIT   = 8'h11;
  localparam logic [7:0] BYTE_CSI    = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SS3    = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] BYTE_UP     = 8'h41;  // 'A'
  localparam logic [7:0] BYTE_DOWN   = 8'h42;  // 'B'
  localparam logic [7:0] BYTE_RIGHT  = 8'h43;  // 'C'
  localparam logic [7:0] BYTE_LEFT   = 8'h44;  // 'D'
  localparam logic [7:0] BYTE_HOME   = 8'h48;  // 'H'
  localparam logic [7:0] BYTE_END    = 8'h46;  // 'F'
  localparam logic [7:0] BYTE_DIG0   = 8'h30;  // '0'
  localparam logic [7:0] BYTE_DIG1   = 8'h31;
  localparam logic [7:0] BYTE_DIG3   = 8'h33;
  localparam logic [7:0] BYTE_DIG4   = 8'h34;
  localparam logic [7:0] BYTE_DIG5   = 8'h35;
  localparam logic [7:0] BYTE_DIG6   = 8'h36;
  localparam logic [7:0] BYTE_DIG7   = 8'h37;
  localparam logic [7:0] BYTE_DIG8   = 8'h38;
  localparam logic [7:0] BYTE_DIG9   = 8'h39;

  typedef enum logic [3:0] {
    KC_PLAIN = 4'd0,
    KC_ESC   = 4'd1,
    KC_LEFT  = 4'd2,
    KC_DOWN  = 4'd3,
    KC_UP    = 4'd4,
    KC_RIGHT = 4'd5,
    KC_HOME  = 4'd6,
    KC_END   = 4'd7,
    KC_PGDN  = 4'd8,
    KC_PGUP  = 4'd9
  } key_code_t;

  // decoded key handed to the cursor unit
  typedef struct packed {
    logic      apply;
    key_code_t code;
  } cursor_cmd_t;

  // result word, tdata part then tuser part
  typedef struct packed {
    logic [PosW-1:0] cursor_col;
    logic [PosW-1:0] cursor_row;
    logic [7:0]      plain_byte;
    logic            quit;
    logic            delete_key;
    key_code_t       key_code;
  } out_word_t;

endpackage

`default_nettype wire

>>> sv/tkd_cursor.sv
// ----------------------------------------------------------------------------
// tkd_cursor
// Cursor row and column, clamped to the screen size and moved by keys.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_cursor
  import tkd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cursor_cmd_t     cmd,
  input  wire logic [PosW-1:0] screen_rows,
  input  wire logic [PosW-1:0] screen_cols,
  output logic      [PosW-1:0] row_nxt,
  output logic      [PosW-1:0] col_nxt
);

  logic [PosW-1:0] row_r;
  logic [PosW-1:0] col_r;
  logic [PosW-1:0] rmax;
  logic [PosW-1:0] cmax;
  logic [PosW-1:0] row_cl;
  logic [PosW-1:0] col_cl;

  // a size of zero counts as one
  assign rmax   = (screen_rows == '0) ? '0 : screen_rows - 1'b1;
  assign cmax   = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
  assign row_cl = (row_r > rmax) ? rmax : row_r;
  assign col_cl = (col_r > cmax) ? cmax : col_r;

  always_comb begin
    row_nxt = row_cl;
    col_nxt = col_cl;
    case (cmd.code)
      KC_LEFT:  if (col_cl != '0) col_nxt = col_cl - 1'b1;
      KC_RIGHT: if (col_cl < cmax) col_nxt = col_cl + 1'b1;
      KC_UP:    if (row_cl != '0) row_nxt = row_cl - 1'b1;
      KC_DOWN:  if (row_cl < rmax) row_nxt = row_cl + 1'b1;
      KC_HOME:  col_nxt = '0;
      KC_END:   col_nxt = cmax;
      KC_PGUP:  row_nxt = '0;
      KC_PGDN:  row_nxt = rmax;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.apply) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/terminal_key_decoder_cursor.sv
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor
// Decodes terminal escape sequences into key codes and tracks a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one terminal byte per word; in_tuser set means the read failed
//            and no byte arrived (closes an open sequence as ESC).
//   out_*  : one word per decoded key; bytes that continue a sequence and
//            empty reads while idle give no word.
//   cfg_*  : screen_rows (index 0) and screen_cols (index 1), written while
//            the block is idle; a value of zero counts as one.
// Each result is registered in the output or skid register. Throughput is
// one byte per cycle: the parser state and cursor update in the same cycle
// the byte is accepted, and a two-entry output buffer (output register plus
// skid register) keeps in_tready high while one word waits.
// When the receiver stalls, a second result fills the skid register and
// in_tready drops until out_tready frees a slot; nothing is dropped.
// Reset (rst_n low, synchronous) empties the output buffer, returns the
// parser to idle, homes the cursor to row 0 column 0 and loads 24 rows and
// 80 columns.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_key_decoder_cursor
  import tkd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] no_byte
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] plain_byte, [19:8] cursor_row,
                                       // [31:20] cursor_col
  output logic [5:0]       out_tuser,  // [3:0] key_code, [4] delete_key, [5] quit
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ESC   = 4'b0010,
    ST_FIRST = 4'b0100,
    ST_DIGIT = 4'b1000
  } phase_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [7:0]      second_r, second_nxt;
  logic [PosW-1:0] rows_r;
  logic [PosW-1:0] cols_r;

  out_word_t       out_r, skid_r, res;
  logic            out_valid_r, skid_valid_r;

  logic            in_fire;
  logic [7:0]      b;
  logic            emit;
  key_code_t       code;
  logic            del;
  logic            is_digit;
  cursor_cmd_t     cur_cmd;
  logic [PosW-1:0] row_nxt;
  logic [PosW-1:0] col_nxt;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign is_digit  = (b >= BYTE_DIG0) && (b <= BYTE_DIG9);

  // sequence parser
  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    emit       = 1'b0;
    code       = KC_PLAIN;
    del        = 1'b0;
    if (in_tuser) begin
      if (phase_r != ST_IDLE) begin
        phase_nxt = ST_IDLE;
        emit      = 1'b1;
        code      = KC_ESC;
      end
    end else begin
      case (phase_r)
        ST_IDLE: begin
          if (b == BYTE_ESC) begin
            phase_nxt = ST_ESC;
          end else begin
            emit = 1'b1;
          end
        end
        ST_ESC: begin
          first_nxt = b;
          phase_nxt = ST_FIRST;
        end
        ST_FIRST: begin
          second_nxt = b;
          if (first_r == BYTE_CSI && is_digit) begin
            phase_nxt = ST_DIGIT;
          end else begin
            phase_nxt = ST_IDLE;
            emit      = 1'b1;
            code      = KC_ESC;
            if (first_r == BYTE_CSI) begin
              case (b)
                BYTE_UP:    code = KC_UP;
                BYTE_DOWN:  code = KC_DOWN;
                BYTE_RIGHT: code = KC_RIGHT;
                BYTE_LEFT:  code = KC_LEFT;
                BYTE_HOME:  code = KC_HOME;
                BYTE_END:   code = KC_END;
                default:    code = KC_ESC;
              endcase
            end else if (first_r == BYTE_SS3) begin
              if (b == BYTE_HOME) code = KC_HOME;
              else if (b == BYTE_END) code = KC_END;
            end
          end
        end
        ST_DIGIT: begin
          phase_nxt = ST_IDLE;
          emit      = 1'b1;
          code      = KC_ESC;
          if (b == BYTE_TILDE) begin
            case (second_r)
              BYTE_DIG1, BYTE_DIG7: code = KC_HOME;
              BYTE_DIG4, BYTE_DIG8: code = KC_END;
              BYTE_DIG5:            code = KC_PGUP;
              BYTE_DIG6:            code = KC_PGDN;
              BYTE_DIG3: begin
                code = KC_PLAIN;
                del  = 1'b1;
              end
              default:              code = KC_ESC;
            endcase
          end
        end
        default: begin
          phase_nxt = ST_IDLE;
        end
      endcase
    end
  end

  assign cur_cmd.apply = in_fire && emit;
  assign cur_cmd.code  = code;

  tkd_cursor u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cur_cmd),
    .screen_rows (rows_r),
    .screen_cols (cols_r),
    .row_nxt     (row_nxt),
    .col_nxt     (col_nxt)
  );

  // result word
  always_comb begin
    res.key_code   = code;
    res.delete_key = del;
    res.cursor_row = row_nxt;
    res.cursor_col = col_nxt;
    if (code == KC_ESC) begin
      res.plain_byte = BYTE_ESC;
    end else if (code == KC_PLAIN && !del) begin
      res.plain_byte = b;
    end else begin
      res.plain_byte = 8'h00;
    end
    res.quit = (code == KC_PLAIN) && !del && (b == BYTE_QUIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ST_IDLE;
      first_r  <= 8'h00;
      second_r <= 8'h00;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 12'd24;
      cols_r <= 12'd80;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= cur_cmd.apply;
      end
    end else if (cur_cmd.apply) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (cur_cmd.apply) begin
        out_r <= res;
      end
    end else if (cur_cmd.apply) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.cursor_col, out_r.cursor_row, out_r.plain_byte};
  assign out_tuser  = {out_r.quit, out_r.delete_key, out_r.key_code};

endmodule

`default_nettype wire
